[rtl/c8alu_pkg.sv]
// ----------------------------------------------------------------------------
// c8alu_pkg
// Shared types and constants of the 8-bit execute stage: item layouts,
// register file layout, operation codes and status flag positions.
// ----------------------------------------------------------------------------
package c8alu_pkg;

  typedef struct packed {
    logic [5:0]  op;
    logic [7:0]  operand_byte;
    logic [15:0] pc;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;
    logic [7:0]  store_data;
    logic        branch_taken;
    logic [15:0] next_pc;
    logic        page_crossed;
  } out_item_t;

  // Architectural registers
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } arch_state_t;

  // Branch unit results
  typedef struct packed {
    logic        taken;
    logic [15:0] target;
    logic        crossed;
  } branch_res_t;

  localparam logic [7:0] ACC_RESET = 8'h00;
  localparam logic [7:0] X_RESET   = 8'h00;
  localparam logic [7:0] Y_RESET   = 8'h00;
  localparam logic [7:0] SP_RESET  = 8'hFD;
  localparam logic [7:0] P_RESET   = 8'h34;

  // Status flag bit positions
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  // Operation codes
  localparam logic [5:0] OP_ORA = 6'd0;
  localparam logic [5:0] OP_AND = 6'd1;
  localparam logic [5:0] OP_EOR = 6'd2;
  localparam logic [5:0] OP_ADC = 6'd3;
  localparam logic [5:0] OP_SBC = 6'd4;
  localparam logic [5:0] OP_CMP = 6'd5;
  localparam logic [5:0] OP_CPX = 6'd6;
  localparam logic [5:0] OP_CPY = 6'd7;
  localparam logic [5:0] OP_BIT = 6'd8;
  localparam logic [5:0] OP_LDA = 6'd9;
  localparam logic [5:0] OP_LDX = 6'd10;
  localparam logic [5:0] OP_LDY = 6'd11;
  localparam logic [5:0] OP_STA = 6'd12;
  localparam logic [5:0] OP_STX = 6'd13;
  localparam logic [5:0] OP_STY = 6'd14;
  localparam logic [5:0] OP_CLC = 6'd15;
  localparam logic [5:0] OP_SEC = 6'd16;
  localparam logic [5:0] OP_CLI = 6'd17;
  localparam logic [5:0] OP_SEI = 6'd18;
  localparam logic [5:0] OP_CLV = 6'd19;
  localparam logic [5:0] OP_CLD = 6'd20;
  localparam logic [5:0] OP_SED = 6'd21;
  localparam logic [5:0] OP_INX = 6'd22;
  localparam logic [5:0] OP_DEX = 6'd23;
  localparam logic [5:0] OP_INY = 6'd24;
  localparam logic [5:0] OP_DEY = 6'd25;
  localparam logic [5:0] OP_TAX = 6'd26;
  localparam logic [5:0] OP_TXA = 6'd27;
  localparam logic [5:0] OP_TAY = 6'd28;
  localparam logic [5:0] OP_TYA = 6'd29;
  localparam logic [5:0] OP_TSX = 6'd30;
  localparam logic [5:0] OP_TXS = 6'd31;
  localparam logic [5:0] OP_NOP = 6'd32;
  localparam logic [5:0] OP_BPL = 6'd33;
  localparam logic [5:0] OP_BEQ = 6'd40;

endpackage

[rtl/cpu_8bit_register_alu_execute.sv]
// ----------------------------------------------------------------------------
// cpu_8bit_register_alu_execute
// Execute stage of an 8-bit accumulator processor, binary arithmetic only.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one decoded instruction per item (op, operand_byte, pc), taken
//           on in_valid && in_ready.
//   out_* : one result item per input item: A, X, Y, SP and status after
//           the instruction, store byte, branch decision, next pc and the
//           page-cross mark, delivered on out_valid && out_ready.
//   An accepted item goes from the input register through the execute
//   logic into the result register. Throughput is one item per cycle
//   unless the receiver stalls; the architectural registers are
//   written on the same edge as the result register, so the next item in
//   the input register always sees the updated A/X/Y/SP/status.
//   Reset clears both stages and loads A=0, X=0, Y=0, SP=0xFD, P=0x34.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, then in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module cpu_8bit_register_alu_execute (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  c8alu_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output c8alu_pkg::out_item_t  out_data
);

  logic                    s1_valid_r;
  c8alu_pkg::in_item_t     s1_item_r;
  c8alu_pkg::arch_state_t  state_r;
  c8alu_pkg::arch_state_t  state_nxt;
  logic                    out_valid_r;
  c8alu_pkg::out_item_t    out_item_r;
  c8alu_pkg::out_item_t    out_item_nxt;
  logic                    out_adv;
  logic                    exec_fire;

  // Result register can load when empty or being drained this cycle
  assign out_adv   = !out_valid_r || out_ready;
  assign exec_fire = s1_valid_r && out_adv;
  assign in_ready  = !s1_valid_r || out_adv;

  c8alu_exec u_exec (
    .item   (s1_item_r),
    .cur    (state_r),
    .nxt    (state_nxt),
    .result (out_item_nxt)
  );

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r.acc <= c8alu_pkg::ACC_RESET;
      state_r.x   <= c8alu_pkg::X_RESET;
      state_r.y   <= c8alu_pkg::Y_RESET;
      state_r.sp  <= c8alu_pkg::SP_RESET;
      state_r.p   <= c8alu_pkg::P_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      // Commit registers together with the result item
      if (exec_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers: hold unless advancing
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (exec_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Bits four and five of status never change from their reset value
  a_p_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status_out[5:4] == 2'b11))
    else $error("status bits 5:4 changed");

  // Input side never stalls while the result side is moving
  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low while result stage free");

  // A new result only appears after an item sat in the input register
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid_r))
    else $error("result appeared without an item");

  // Page cross only reported with a taken branch
  a_cross_needs_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.page_crossed || out_data.branch_taken))
    else $error("page cross without taken branch");

endmodule

[rtl/c8alu_branch.sv]
// ----------------------------------------------------------------------------
// c8alu_branch
// Conditional branch evaluation, target adder and page-cross detect.
// ----------------------------------------------------------------------------
module c8alu_branch (
  input  logic [5:0]                op,
  input  logic [7:0]                offset,
  input  logic [15:0]               pc,
  input  logic [7:0]                flags,
  output c8alu_pkg::branch_res_t    res
);

  logic [5:0]  k_full;
  logic [2:0]  k;
  logic        is_branch;
  logic        flag_set;
  logic [15:0] target;

  assign is_branch = (op >= c8alu_pkg::OP_BPL) && (op <= c8alu_pkg::OP_BEQ);
  assign k_full    = op - c8alu_pkg::OP_BPL;
  assign k         = k_full[2:0];
  assign target    = pc + {{8{offset[7]}}, offset};

  // Pairs of codes test N, V, C, Z; the second (even) code of a pair branches on set
  always_comb begin
    case (k[2:1])
      2'd0:    flag_set = flags[c8alu_pkg::FL_N];
      2'd1:    flag_set = flags[c8alu_pkg::FL_V];
      2'd2:    flag_set = flags[c8alu_pkg::FL_C];
      default: flag_set = flags[c8alu_pkg::FL_Z];
    endcase
  end

  always_comb begin
    res.taken   = is_branch && (k[0] ? flag_set : !flag_set);
    res.target  = res.taken ? target : pc;
    res.crossed = res.taken && (target[15:8] != pc[15:8]);
  end

endmodule

[rtl/c8alu_exec.sv]
// ----------------------------------------------------------------------------
// c8alu_exec
// Single-pass datapath: computes next register state and the result item.
// ----------------------------------------------------------------------------
module c8alu_exec (
  input  c8alu_pkg::in_item_t     item,
  input  c8alu_pkg::arch_state_t  cur,
  output c8alu_pkg::arch_state_t  nxt,
  output c8alu_pkg::out_item_t    result
);

  c8alu_pkg::branch_res_t br;

  logic [7:0] m;
  logic [7:0] addend;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;

  c8alu_branch u_branch (
    .op     (item.op),
    .offset (item.operand_byte),
    .pc     (item.pc),
    .flags  (cur.p),
    .res    (br)
  );

  assign m       = item.operand_byte;
  // SBC adds the inverted operand
  assign addend  = (item.op == c8alu_pkg::OP_SBC) ? ~m : m;
  assign sum     = {1'b0, cur.acc} + {1'b0, addend} + {8'd0, cur.p[c8alu_pkg::FL_C]};
  assign cmp_reg = (item.op == c8alu_pkg::OP_CPX) ? cur.x :
                   (item.op == c8alu_pkg::OP_CPY) ? cur.y : cur.acc;
  assign diff    = {1'b0, cmp_reg} - {1'b0, m};

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q                    = p;
    q[c8alu_pkg::FL_N]   = v[7];
    q[c8alu_pkg::FL_Z]   = (v == 8'd0);
    return q;
  endfunction

  always_comb begin
    nxt = cur;
    result.store_data = 8'd0;
    unique case (item.op) inside
      c8alu_pkg::OP_ORA: begin
        nxt.acc = cur.acc | m;
        nxt.p   = set_nz(cur.p, cur.acc | m);
      end
      c8alu_pkg::OP_AND: begin
        nxt.acc = cur.acc & m;
        nxt.p   = set_nz(cur.p, cur.acc & m);
      end
      c8alu_pkg::OP_EOR: begin
        nxt.acc = cur.acc ^ m;
        nxt.p   = set_nz(cur.p, cur.acc ^ m);
      end
      c8alu_pkg::OP_ADC, c8alu_pkg::OP_SBC: begin
        nxt.acc = sum[7:0];
        nxt.p   = set_nz(cur.p, sum[7:0]);
        nxt.p[c8alu_pkg::FL_C] = sum[8];
        nxt.p[c8alu_pkg::FL_V] = ~(cur.acc[7] ^ addend[7]) & (cur.acc[7] ^ sum[7]);
      end
      c8alu_pkg::OP_CMP, c8alu_pkg::OP_CPX, c8alu_pkg::OP_CPY: begin
        nxt.p = set_nz(cur.p, diff[7:0]);
        nxt.p[c8alu_pkg::FL_C] = !diff[8];
      end
      c8alu_pkg::OP_BIT: begin
        nxt.p[c8alu_pkg::FL_Z] = ((cur.acc & m) == 8'd0);
        nxt.p[c8alu_pkg::FL_V] = m[6];
        nxt.p[c8alu_pkg::FL_N] = m[7];
      end
      c8alu_pkg::OP_LDA: begin
        nxt.acc = m;
        nxt.p   = set_nz(cur.p, m);
      end
      c8alu_pkg::OP_LDX: begin
        nxt.x = m;
        nxt.p = set_nz(cur.p, m);
      end
      c8alu_pkg::OP_LDY: begin
        nxt.y = m;
        nxt.p = set_nz(cur.p, m);
      end
      c8alu_pkg::OP_STA: result.store_data = cur.acc;
      c8alu_pkg::OP_STX: result.store_data = cur.x;
      c8alu_pkg::OP_STY: result.store_data = cur.y;
      c8alu_pkg::OP_CLC: nxt.p[c8alu_pkg::FL_C] = 1'b0;
      c8alu_pkg::OP_SEC: nxt.p[c8alu_pkg::FL_C] = 1'b1;
      c8alu_pkg::OP_CLI: nxt.p[c8alu_pkg::FL_I] = 1'b0;
      c8alu_pkg::OP_SEI: nxt.p[c8alu_pkg::FL_I] = 1'b1;
      c8alu_pkg::OP_CLV: nxt.p[c8alu_pkg::FL_V] = 1'b0;
      c8alu_pkg::OP_CLD: nxt.p[c8alu_pkg::FL_D] = 1'b0;
      c8alu_pkg::OP_SED: nxt.p[c8alu_pkg::FL_D] = 1'b1;
      c8alu_pkg::OP_INX: begin
        nxt.x = cur.x + 8'd1;
        nxt.p = set_nz(cur.p, cur.x + 8'd1);
      end
      c8alu_pkg::OP_DEX: begin
        nxt.x = cur.x - 8'd1;
        nxt.p = set_nz(cur.p, cur.x - 8'd1);
      end
      c8alu_pkg::OP_INY: begin
        nxt.y = cur.y + 8'd1;
        nxt.p = set_nz(cur.p, cur.y + 8'd1);
      end
      c8alu_pkg::OP_DEY: begin
        nxt.y = cur.y - 8'd1;
        nxt.p = set_nz(cur.p, cur.y - 8'd1);
      end
      c8alu_pkg::OP_TAX: begin
        nxt.x = cur.acc;
        nxt.p = set_nz(cur.p, cur.acc);
      end
      c8alu_pkg::OP_TXA: begin
        nxt.acc = cur.x;
        nxt.p   = set_nz(cur.p, cur.x);
      end
      c8alu_pkg::OP_TAY: begin
        nxt.y = cur.acc;
        nxt.p = set_nz(cur.p, cur.acc);
      end
      c8alu_pkg::OP_TYA: begin
        nxt.acc = cur.y;
        nxt.p   = set_nz(cur.p, cur.y);
      end
      c8alu_pkg::OP_TSX: begin
        nxt.x = cur.sp;
        nxt.p = set_nz(cur.p, cur.sp);
      end
      c8alu_pkg::OP_TXS: nxt.sp = cur.x;
      // NOP, branches and unused codes leave registers alone
      default: ;
    endcase

    result.acc_out      = nxt.acc;
    result.x_out        = nxt.x;
    result.y_out        = nxt.y;
    result.sp_out       = nxt.sp;
    result.status_out   = nxt.p;
    result.branch_taken = br.taken;
    result.next_pc      = br.target;
    result.page_crossed = br.crossed;
  end

endmodule
